// ===== rtl/core/per_cpu_page_frame_allocator_defines.svh =====
// Assertion macros shared by the page frame allocator RTL.
`ifndef PER_CPU_PAGE_FRAME_ALLOCATOR_DEFINES_SVH
`define PER_CPU_PAGE_FRAME_ALLOCATOR_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define PCPA_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pcpa: same-cycle check failed");

// next-cycle implication, clocked on clk, off during reset
`define PCPA_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pcpa: next-cycle check failed");

`endif

// ===== rtl/core/pcpa_pkg.sv =====
// Shared constants and types of the page frame allocator.
package pcpa_pkg;

    localparam int ADDR_W     = 32;
    localparam int PAGE_SHIFT = 12;
    localparam int PAGE_IDX_W = ADDR_W + 1 - PAGE_SHIFT;

    // request codes
    localparam logic [1:0] REQ_ALLOC = 2'd0;
    localparam logic [1:0] REQ_FREE  = 2'd1;
    localparam logic [1:0] REQ_INIT  = 2'd2;

    // status codes
    localparam logic [1:0] STAT_DONE     = 2'd0;
    localparam logic [1:0] STAT_NO_PAGE  = 2'd1;
    localparam logic [1:0] STAT_BAD_ADDR = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_REGION_START = 2'd0;
    localparam logic [1:0] CFG_REGION_STOP  = 2'd1;

    localparam logic [ADDR_W-1:0] REGION_START_RESET = 32'h8000_0000;
    localparam logic [ADDR_W-1:0] REGION_STOP_RESET  = 32'h8800_0000;
    localparam logic [ADDR_W:0]   BASE_RESET         = 33'h0_8000_0000;

    typedef struct packed {
        logic                  bad;
        logic [PAGE_IDX_W-1:0] page;
    } free_chk_t;

endpackage

// ===== rtl/core/per_cpu_page_frame_allocator.sv =====
// Per-CPU page frame allocator: LIFO free lists linked through one link memory.
// One transaction at a time. Free and unused request types finish in the execute state;
// alloc adds a pop state for the registered link memory read; init adds one link write a
// cycle per page (N pages). The result is registered; if the output stalls it parks in a
// hold state. The next request is accepted once back in idle. Reset empties all lists;
// the link memory is not cleared and only holds entries of pushed pages.
`include "per_cpu_page_frame_allocator_defines.svh"

module per_cpu_page_frame_allocator #(
    parameter int CPU_COUNT = 8,
    parameter int MAX_PAGES = 32768
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_index,
    input  logic [pcpa_pkg::ADDR_W-1:0] cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [1:0]                  req_type,
    input  logic [2:0]                  cpu_id,
    input  logic [pcpa_pkg::ADDR_W-1:0] page_addr,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [1:0]                  status,
    output logic [pcpa_pkg::ADDR_W-1:0] alloc_addr
);
    import pcpa_pkg::*;

    localparam int CW = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
    localparam int PW = $clog2(MAX_PAGES);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EXEC = 3'd1;
    localparam logic [2:0] ST_POP  = 3'd2;
    localparam logic [2:0] ST_INIT = 3'd3;
    localparam logic [2:0] ST_HOLD = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [ADDR_W-1:0] start_reg, stop_reg;
    logic [ADDR_W:0]   base_reg, base_next;
    logic [CPU_COUNT-1:0] hv_reg, hv_next;
    logic [PW-1:0]     head_reg [CPU_COUNT];
    logic [PW-1:0]     head_next [CPU_COUNT];
    logic [1:0]        req_reg, req_next;
    logic [CW-1:0]     cpu_reg, cpu_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [CW-1:0]     sel_reg, sel_next;
    logic [PW-1:0]     pop_idx_reg, pop_idx_next;
    logic [PW:0]       n_reg, n_next;
    logic [PW:0]       cnt_reg, cnt_next;
    logic              out_valid_reg, out_valid_next;
    logic [1:0]        status_reg, status_next;
    logic [ADDR_W-1:0] alloc_addr_reg, alloc_addr_next;
    logic [1:0]        hold_status_reg, hold_status_next;
    logic [ADDR_W-1:0] hold_addr_reg, hold_addr_next;

    // link memory: {successor valid, successor index}
    logic [PW:0]       link_mem [MAX_PAGES];
    logic [PW:0]       mem_rd_reg;
    logic              mem_we;
    logic [PW-1:0]     mem_wa, mem_ra;
    logic [PW:0]       mem_wd;

    logic [2:0]        cpu_m;
    logic [CW-1:0]     low_pick, pick, hd_ra;
    logic [PW-1:0]     head_rd;
    logic              any_valid;
    logic              out_free;
    logic              fin;
    logic [1:0]        fin_status;
    logic [ADDR_W-1:0] fin_addr;
    logic [ADDR_W:0]   base_new, base_sum, span;
    logic [PAGE_IDX_W-1:0] span_pages;
    free_chk_t         chk;

    pcpa_free_check #(
        .MAX_PAGES(MAX_PAGES)
    ) u_free_check (
        .addr(addr_reg),
        .region_start(start_reg),
        .region_stop(stop_reg),
        .base(base_reg),
        .chk(chk)
    );

    assign in_stall   = (state_reg != ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign alloc_addr = alloc_addr_reg;
    assign out_free   = !out_valid_reg || !out_stall;

    // fold an out-of-range cpu_id back into the CPU range
    always_comb
    begin
        cpu_m = cpu_id;
        for (int k = 0; k < 8; k++)
        begin
            if (int'(cpu_m) >= CPU_COUNT)
                cpu_m = cpu_m - 3'(CPU_COUNT);
        end
    end

    // lender pick: own list first, else the lowest non-empty list
    always_comb
    begin
        low_pick = '0;
        for (int k = CPU_COUNT - 1; k >= 0; k--)
        begin
            if (hv_reg[k])
                low_pick = CW'(k);
        end
        any_valid = |hv_reg;
        pick      = hv_reg[cpu_reg] ? cpu_reg : low_pick;
        hd_ra     = (req_reg == REQ_ALLOC) ? pick : cpu_reg;
        head_rd   = head_reg[hd_ra];
    end

    // page count of the region for init
    always_comb
    begin
        base_sum   = {1'b0, start_reg} + {{(ADDR_W + 1 - PAGE_SHIFT){1'b0}},
                                          {PAGE_SHIFT{1'b1}}};
        base_new   = {base_sum[ADDR_W:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
        span       = {1'b0, stop_reg} - base_new;
        span_pages = span[ADDR_W:PAGE_SHIFT];
    end

    always_comb
    begin
        state_next       = state_reg;
        base_next        = base_reg;
        hv_next          = hv_reg;
        head_next        = head_reg;
        req_next         = req_reg;
        cpu_next         = cpu_reg;
        addr_next        = addr_reg;
        sel_next         = sel_reg;
        pop_idx_next     = pop_idx_reg;
        n_next           = n_reg;
        cnt_next         = cnt_reg;
        out_valid_next   = out_valid_reg;
        status_next      = status_reg;
        alloc_addr_next  = alloc_addr_reg;
        hold_status_next = hold_status_reg;
        hold_addr_next   = hold_addr_reg;
        mem_we           = 1'b0;
        mem_wa           = n_reg[PW-1:0];
        mem_wd           = '0;
        mem_ra           = head_rd;
        fin              = 1'b0;
        fin_status       = STAT_DONE;
        fin_addr         = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    req_next   = req_type;
                    cpu_next   = CW'(cpu_m);
                    addr_next  = page_addr;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                case (req_reg)
                    REQ_ALLOC:
                    begin
                        if (!any_valid)
                        begin
                            fin        = 1'b1;
                            fin_status = STAT_NO_PAGE;
                        end
                        else
                        begin
                            // link read issued at the head of the chosen list
                            sel_next     = pick;
                            pop_idx_next = head_rd;
                            state_next   = ST_POP;
                        end
                    end
                    REQ_FREE:
                    begin
                        fin = 1'b1;
                        if (chk.bad)
                            fin_status = STAT_BAD_ADDR;
                        else
                        begin
                            mem_we             = 1'b1;
                            mem_wa             = chk.page[PW-1:0];
                            mem_wd             = {hv_reg[cpu_reg], head_rd};
                            hv_next[cpu_reg]   = 1'b1;
                            head_next[cpu_reg] = chk.page[PW-1:0];
                        end
                    end
                    REQ_INIT:
                    begin
                        hv_next   = '0;
                        base_next = base_new;
                        n_next    = '0;
                        if ({1'b0, stop_reg} < base_new)
                            cnt_next = '0;
                        else if (span_pages >= PAGE_IDX_W'(MAX_PAGES))
                            cnt_next = (PW + 1)'(MAX_PAGES);
                        else
                            cnt_next = span_pages[PW:0];
                        state_next = ST_INIT;
                    end
                    default:
                    begin
                        fin = 1'b1;
                    end
                endcase
            end
            ST_POP:
            begin
                hv_next[sel_reg]   = mem_rd_reg[PW];
                head_next[sel_reg] = mem_rd_reg[PW-1:0];
                fin                = 1'b1;
                fin_addr           = base_reg[ADDR_W-1:0] +
                                     (ADDR_W'(pop_idx_reg) << PAGE_SHIFT);
            end
            ST_INIT:
            begin
                if (n_reg == cnt_reg)
                    fin = 1'b1;
                else
                begin
                    // push page n: its successor is page n-1
                    mem_we             = 1'b1;
                    mem_wa             = n_reg[PW-1:0];
                    mem_wd             = {(n_reg != '0), n_reg[PW-1:0] - 1'b1};
                    hv_next[cpu_reg]   = 1'b1;
                    head_next[cpu_reg] = n_reg[PW-1:0];
                    n_next             = n_reg + 1'b1;
                end
            end
            ST_HOLD:
            begin
                fin        = 1'b1;
                fin_status = hold_status_reg;
                fin_addr   = hold_addr_reg;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        if (fin)
        begin
            if (out_free)
            begin
                out_valid_next  = 1'b1;
                status_next     = fin_status;
                alloc_addr_next = fin_addr;
                state_next      = ST_IDLE;
            end
            else
            begin
                // output still full: park the result
                hold_status_next = fin_status;
                hold_addr_next   = fin_addr;
                state_next       = ST_HOLD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            start_reg     <= REGION_START_RESET;
            stop_reg      <= REGION_STOP_RESET;
            base_reg      <= BASE_RESET;
            hv_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            base_reg      <= base_next;
            hv_reg        <= hv_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we && (cfg_index == CFG_REGION_START))
                start_reg <= cfg_data;
            if (cfg_we && (cfg_index == CFG_REGION_STOP))
                stop_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg        <= head_next;
        req_reg         <= req_next;
        cpu_reg         <= cpu_next;
        addr_reg        <= addr_next;
        sel_reg         <= sel_next;
        pop_idx_reg     <= pop_idx_next;
        n_reg           <= n_next;
        cnt_reg         <= cnt_next;
        status_reg      <= status_next;
        alloc_addr_reg  <= alloc_addr_next;
        hold_status_reg <= hold_status_next;
        hold_addr_reg   <= hold_addr_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            link_mem[mem_wa] <= mem_wd;
        mem_rd_reg <= link_mem[mem_ra];
    end

    `PCPA_ASSERT_IMP(a_pop_list_live, state_reg == ST_POP, hv_reg[sel_reg])
    `PCPA_ASSERT_IMP(a_init_bound, state_reg == ST_INIT, n_reg <= cnt_reg)
    `PCPA_ASSERT_IMP(a_hold_busy, state_reg == ST_HOLD, out_valid_reg)
    `PCPA_ASSERT_NXT(a_accept_exec, in_valid && !in_stall, state_reg == ST_EXEC)

endmodule

// ===== rtl/core/pcpa_free_check.sv =====
// Address check and page index for a free transaction.
module pcpa_free_check #(
    parameter int MAX_PAGES = 32768
) (
    input  logic [pcpa_pkg::ADDR_W-1:0] addr,
    input  logic [pcpa_pkg::ADDR_W-1:0] region_start,
    input  logic [pcpa_pkg::ADDR_W-1:0] region_stop,
    input  logic [pcpa_pkg::ADDR_W:0]   base,
    output pcpa_pkg::free_chk_t         chk
);
    import pcpa_pkg::*;

    logic [ADDR_W:0] diff;

    always_comb
    begin
        diff     = {1'b0, addr} - base;
        chk.page = diff[ADDR_W:PAGE_SHIFT];
        chk.bad  = (addr[PAGE_SHIFT-1:0] != '0) ||
                   (addr < region_start) ||
                   (addr >= region_stop) ||
                   ({1'b0, addr} < base) ||
                   (chk.page >= PAGE_IDX_W'(MAX_PAGES));
    end

endmodule

// ===== verif/per_cpu_page_frame_allocator_tb.sv =====
// Self-checking testbench for the per-CPU page frame allocator.
module per_cpu_page_frame_allocator_tb;
    import pcpa_pkg::*;

    localparam int CPU_COUNT      = 8;
    localparam int MAX_PAGES      = 32768;
    localparam int IDX_W          = $clog2(MAX_PAGES);
    localparam int PAGE_BYTES     = 4096;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 200000;
    localparam int RANDOM_PHASES  = 16;
    localparam int PHASE_ITEMS    = 58;

    typedef struct packed {
        logic [1:0]        status;
        logic [ADDR_W-1:0] addr;
    } reply_t;

    logic              clk;
    logic              rst_n     = 1'b0;
    logic              cfg_we    = 1'b0;
    logic [1:0]        cfg_index = CFG_REGION_START;
    logic [ADDR_W-1:0] cfg_data  = '0;
    logic              in_valid  = 1'b0;
    logic              in_stall;
    logic [1:0]        req_type  = REQ_ALLOC;
    logic [2:0]        cpu_id    = '0;
    logic [ADDR_W-1:0] page_addr = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [1:0]        status;
    logic [ADDR_W-1:0] alloc_addr;

    // free list model
    bit              head_ok  [CPU_COUNT];
    bit [IDX_W-1:0]  head_idx [CPU_COUNT];
    bit              link_ok  [MAX_PAGES];
    bit [IDX_W-1:0]  link_idx [MAX_PAGES];
    bit [ADDR_W:0]   page_base;
    bit [ADDR_W-1:0] cur_start;
    bit [ADDR_W-1:0] cur_stop;

    reply_t            reply_q[$];
    reply_t            last_reply;
    reply_t            got_reply;
    logic [ADDR_W-1:0] owned_pages[$];

    bit idle_on      = 1'b1;
    int fail_count   = 0;
    int hold_seq     = 0;
    int hold_seen    = 0;
    int hold_left    = 0;
    int quiet_cycles = 0;

    per_cpu_page_frame_allocator #(
        .CPU_COUNT(CPU_COUNT),
        .MAX_PAGES(MAX_PAGES)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .cpu_id    (cpu_id),
        .page_addr (page_addr),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .alloc_addr(alloc_addr)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic void push_free(input int cpu, input bit [IDX_W-1:0] idx);
        link_ok[idx]  = head_ok[cpu];
        link_idx[idx] = head_idx[cpu];
        head_ok[cpu]  = 1'b1;
        head_idx[cpu] = idx;
    endfunction

    function automatic bit pop_free(input int cpu, output bit [IDX_W-1:0] idx);
        if (!head_ok[cpu])
            return 1'b0;
        idx           = head_idx[cpu];
        head_ok[cpu]  = link_ok[idx];
        head_idx[cpu] = link_idx[idx];
        return 1'b1;
    endfunction

    // Apply one request to the model and return the reply it must produce.
    function automatic reply_t serve_request(input logic [1:0] rq, input logic [2:0] cpu,
                                             input logic [ADDR_W-1:0] addr);
        reply_t         r;
        bit             got;
        bit [IDX_W-1:0] idx;
        bit [63:0]      a;
        bit [63:0]      p;
        int             n;
        int             i;
        r.status = STAT_DONE;
        r.addr   = '0;
        idx      = '0;
        case (rq)
            REQ_ALLOC:
            begin
                got = pop_free(int'(cpu), idx);
                // steal from the lowest-numbered other CPU
                for (i = 0; i < CPU_COUNT && !got; i++)
                    if (i != int'(cpu))
                        got = pop_free(i, idx);
                if (got)
                begin
                    a      = 64'(page_base) + (64'(idx) << PAGE_SHIFT);
                    r.addr = a[ADDR_W-1:0];
                end
                else
                    r.status = STAT_NO_PAGE;
            end
            REQ_FREE:
            begin
                a = 64'(addr);
                if (addr[PAGE_SHIFT-1:0] != '0 || addr < cur_start || addr >= cur_stop ||
                    a < 64'(page_base) ||
                    ((a - 64'(page_base)) >> PAGE_SHIFT) >= 64'(MAX_PAGES))
                    r.status = STAT_BAD_ADDR;
                else
                    push_free(int'(cpu), IDX_W'((a - 64'(page_base)) >> PAGE_SHIFT));
            end
            REQ_INIT:
            begin
                for (i = 0; i < CPU_COUNT; i++)
                begin
                    head_ok[i]  = 1'b0;
                    head_idx[i] = '0;
                end
                page_base = ({1'b0, cur_start} + 33'hFFF) & ~33'hFFF;
                p = 64'(page_base);
                n = 0;
                while (p + 64'(PAGE_BYTES) <= 64'(cur_stop) && n < MAX_PAGES)
                begin
                    push_free(int'(cpu), IDX_W'(n));
                    n++;
                    p += 64'(PAGE_BYTES);
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // Offer one transaction, hold it until accepted, then queue its expected reply.
    task automatic send_request(input logic [1:0] rq, input logic [2:0] cpu,
                                input logic [ADDR_W-1:0] addr);
        while (idle_on && $urandom_range(99) < 17)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        req_type  <= rq;
        cpu_id    <= cpu;
        page_addr <= addr;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        last_reply = serve_request(rq, cpu, addr);
        reply_q.push_back(last_reply);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (reply_q.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic set_region(input logic [ADDR_W-1:0] start, input logic [ADDR_W-1:0] stop);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_REGION_START;
        cfg_data  <= start;
        @(posedge clk);
        cfg_index <= CFG_REGION_STOP;
        cfg_data  <= stop;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_start = start;
        cur_stop  = stop;
        @(posedge clk);
    endtask

    task automatic random_request();
        int                pick;
        int                slot;
        logic [2:0]        cpu;
        logic [ADDR_W-1:0] addr;
        pick = $urandom_range(99);
        cpu  = 3'($urandom_range(CPU_COUNT - 1));
        addr = $urandom;
        if (pick < 80 && pick >= 45 && owned_pages.size() != 0)
        begin
            // give back a page handed out earlier
            slot = $urandom_range(owned_pages.size() - 1);
            addr = owned_pages[slot];
            owned_pages.delete(slot);
            send_request(REQ_FREE, cpu, addr);
        end
        else if (pick >= 80 && pick < 90)
        begin
            case ($urandom_range(2))
                0: addr = $urandom;
                1: addr = {cur_stop[ADDR_W-1:PAGE_SHIFT], 12'h000}
                          + $urandom_range(0, 2) * PAGE_BYTES;
                default: addr = cur_start + $urandom_range(0, 40) * PAGE_BYTES;
            endcase
            send_request(REQ_FREE, cpu, addr);
        end
        else if (pick >= 90 && pick < 95)
            send_request(2'd3, cpu, addr);
        else if (pick >= 95 && pick < 97)
        begin
            owned_pages.delete();
            send_request(REQ_INIT, cpu, addr);
        end
        else
        begin
            send_request(REQ_ALLOC, cpu, addr);
            if (last_reply.status == STAT_DONE)
                owned_pages.push_back(last_reply.addr);
        end
    endtask

    // Lists are empty after reset; the reset base still governs frees.
    task automatic test_reset_lists();
        send_request(REQ_ALLOC, 3'd0, 32'h0000_0000);
        send_request(REQ_FREE, 3'd7, 32'h8000_0000);
        send_request(REQ_FREE, 3'd2, 32'h87FF_F000);
        send_request(REQ_FREE, 3'd2, 32'h8800_0000);
        send_request(REQ_FREE, 3'd1, 32'h8000_0800);
        send_request(REQ_FREE, 3'd1, 32'h0000_0000);
        send_request(REQ_ALLOC, 3'd2, 32'hFFFF_FFFF);
        send_request(REQ_ALLOC, 3'd0, 32'h0000_0000);
        send_request(2'd3, 3'd5, 32'hFFFF_FFFF);
    endtask

    task automatic test_steal_order();
        set_region(32'h8000_0123, 32'h8000_4123);
        send_request(REQ_INIT, 3'd4, 32'h0);
        send_request(REQ_ALLOC, 3'd4, 32'h0);
        send_request(REQ_FREE, 3'd6, 32'h8000_3000);
        send_request(REQ_ALLOC, 3'd1, 32'h0);
        send_request(REQ_ALLOC, 3'd0, 32'h0);
        send_request(REQ_ALLOC, 3'd0, 32'h0);
        send_request(REQ_ALLOC, 3'd0, 32'h0);
        // double free goes through and hands the page out twice
        send_request(REQ_FREE, 3'd3, 32'h8000_3000);
        send_request(REQ_FREE, 3'd3, 32'h8000_3000);
        send_request(REQ_ALLOC, 3'd3, 32'h0);
        send_request(REQ_ALLOC, 3'd3, 32'h0);
        // lower the start after init: base stays latched
        set_region(32'h8000_0000, 32'h8000_5000);
        send_request(REQ_FREE, 3'd3, 32'h8000_0000);
        send_request(REQ_FREE, 3'd3, 32'h8000_4000);
    endtask

    task automatic test_region_extremes();
        // start rounds up past the top of the address space
        set_region(32'hFFFF_F001, 32'hFFFF_FFFF);
        send_request(REQ_INIT, 3'd7, 32'h0);
        send_request(REQ_ALLOC, 3'd7, 32'h0);
        send_request(REQ_FREE, 3'd7, 32'hFFFF_F000);
        // whole space: only the first MAX_PAGES pages are managed
        set_region(32'h0000_0000, 32'hFFFF_FFFF);
        send_request(REQ_INIT, 3'd0, 32'h0);
        send_request(REQ_ALLOC, 3'd5, 32'h0);
        send_request(REQ_FREE, 3'd5, 32'h0800_0000);
        set_region(32'hFFFF_FFFF, 32'h0000_0000);
        send_request(REQ_INIT, 3'd1, 32'h0);
        send_request(REQ_ALLOC, 3'd1, 32'h0);
    endtask

    task automatic test_backpressure();
        set_region(32'h4000_0000, 32'h4001_0000);
        owned_pages.delete();
        send_request(REQ_INIT, 3'd2, 32'h0);
        // hold the output while the sender keeps offering
        hold_seq <= hold_seq + 1;
        repeat (30) random_request();
        wait_idle();
    endtask

    task automatic test_random_traffic();
        int                phase;
        int                k;
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] stop;
        logic [ADDR_W:0]   span;
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            start = $urandom;
            if ($urandom_range(1) == 1)
                start[PAGE_SHIFT-1:0] = '0;
            span = {1'b0, start} + 33'($urandom_range(0, 40) * PAGE_BYTES)
                   + 33'($urandom_range(0, PAGE_BYTES - 1));
            stop = span[ADDR_W] ? '1 : span[ADDR_W-1:0];
            if ($urandom_range(7) == 0)
                stop = start - $urandom_range(0, 3) * PAGE_BYTES;
            set_region(start, stop);
            idle_on = (phase != 3 && phase != 4);
            owned_pages.delete();
            send_request(REQ_INIT, 3'($urandom_range(CPU_COUNT - 1)), $urandom);
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                // widen the region mid-phase without a new init
                if (phase % 4 == 2 && k == PHASE_ITEMS / 2)
                    set_region(start - $urandom_range(0, 3) * PAGE_BYTES,
                               stop + $urandom_range(0, 3) * PAGE_BYTES);
                random_request();
            end
        end
        idle_on = 1'b1;
    endtask

    // Check each result and drive the output stall.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (reply_q.size() == 0)
            begin
                $error("result with nothing pending: status %0d alloc_addr %h",
                       status, alloc_addr);
                fail_count++;
            end
            else
            begin
                got_reply = reply_q.pop_front();
                if (status !== got_reply.status)
                begin
                    $error("status: expected %0d, actual %0d", got_reply.status, status);
                    fail_count++;
                end
                if (alloc_addr !== got_reply.addr)
                begin
                    $error("alloc_addr: expected %h, actual %h", got_reply.addr, alloc_addr);
                    fail_count++;
                end
            end
        end
        if (hold_seen != hold_seq)
        begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= idle_on && ($urandom_range(99) < 17);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        page_base = BASE_RESET;
        cur_start = REGION_START_RESET;
        cur_stop  = REGION_STOP_RESET;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_lists();
        test_steal_order();
        test_region_extremes();
        test_backpressure();
        test_random_traffic();
        wait_idle();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
